@@ rtl/scfr_pkg.sv @@
// Package for the sync/CRC-8 frame receiver.
// Holds the frame type, window constants and the byte-wide CRC-8 step.
// No dependencies.
package scfr_pkg;

	localparam int unsigned CELL_COUNT = 8;

	localparam logic [3:0]  WIN_LEN    = 4'd9;
	localparam logic [7:0]  CRC_INIT   = 8'hFF;
	localparam logic [7:0]  CRC_POLY   = 8'h07;
	localparam logic [7:0]  CRC_TOP    = 8'h80;
	localparam logic [7:0]  SYNC_RESET = 8'hAA;
	localparam logic [15:0] SKIP_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [7:0]         node_id;
		logic [7:0]         opcode;
		logic signed [31:0] payload;
		logic [7:0]         seq;
		logic [7:0]         crc_byte;
		logic [15:0]        skipped_bytes;
	} frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/scfr_cell.sv @@
// One cell of the receive chain: holds one window byte and the running CRC-8
// of the frame candidate that starts at that byte. Depends on scfr_pkg.
module scfr_cell (
	input  logic       clk,
	input  logic       shift_en,
	input  logic [7:0] rx_byte,
	input  logic [7:0] byte_in,
	input  logic [7:0] crc_in,
	output logic [7:0] byte_q,
	output logic [7:0] crc_q
);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
			crc_q  <= scfr_pkg::crc8_byte(crc_in, rx_byte);
		end
	end

endmodule

@@ rtl/scfr_out_buf.sv @@
// Output register with one skid entry for decoded frames.
// Depends on scfr_pkg.
module scfr_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scfr_pkg::frame_t  push_frame,
	input  logic              out_stall,
	output logic              out_valid,
	output scfr_pkg::frame_t  out_frame,
	output logic              full
);

	logic             out_valid_q;
	logic             skid_valid_q;
	scfr_pkg::frame_t out_frame_q;
	scfr_pkg::frame_t skid_frame_q;
	logic             pop;

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (pop || !out_valid_q) begin
				out_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_frame_q <= skid_frame_q;
			end
		end else if (pop || !out_valid_q) begin
			if (push) begin
				out_frame_q <= push_frame;
			end
		end else if (push) begin
			skid_frame_q <= push_frame;
		end
	end

	assign out_valid = out_valid_q;
	assign out_frame = out_frame_q;
	assign full      = skid_valid_q;

endmodule

@@ rtl/sync_crc_frame_receiver_core.sv @@
// Top level of the sync/CRC-8 frame receiver.
// Depends on scfr_pkg, scfr_cell and scfr_out_buf.
//
// The block takes one received byte per transaction on the input channel
// (in_valid, in_stall, rx_byte) and delivers one decoded frame per
// transaction on the output channel (out_valid, out_stall and the fields).
// A frame is nine bytes: the sync byte, node id, opcode, a little-endian
// signed 32-bit payload, a sequence number and a CRC-8 (polynomial 0x07,
// init 0xFF, MSB first) over the first eight bytes.
// A byte is accepted each cycle that has in_valid high and in_stall low.
// The frame closed by a byte is registered in the output or skid entry.
// Eight cells each hold one byte and the running CRC of the candidate frame
// that starts there; the CRC thus costs one byte step per accepting cycle.
// Reset clears the fill count, the skip count and out_valid, and loads the sync
// value 0xAA; cfg_we writes a new sync value from cfg_wdata.
// When the receiver stalls, one more frame is held in a skid entry; bytes
// keep flowing until that entry fills, and then in_stall rises.
module sync_crc_frame_receiver_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         node_id,
	output logic [7:0]         opcode,
	output logic signed [31:0] payload,
	output logic [7:0]         seq,
	output logic [7:0]         crc_byte,
	output logic [15:0]        skipped_bytes
);

	logic [7:0]       sync_q;
	logic [3:0]       fill_q;
	logic [15:0]      skip_q;
	logic [15:0]      skip_next;
	logic             accept;
	logic             match;
	logic             buf_full;
	logic [7:0]       byte_chain [0:scfr_pkg::CELL_COUNT-1];
	logic [7:0]       crc_chain  [0:scfr_pkg::CELL_COUNT-1];
	scfr_pkg::frame_t new_frame;
	scfr_pkg::frame_t out_frame;

	assign in_stall = buf_full;
	assign accept   = in_valid && !in_stall;

	for (genvar i = 0; i < scfr_pkg::CELL_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_head
			scfr_cell u_cell (
				.clk      (clk),
				.shift_en (accept),
				.rx_byte  (rx_byte),
				.byte_in  (rx_byte),
				.crc_in   (scfr_pkg::CRC_INIT),
				.byte_q   (byte_chain[i]),
				.crc_q    (crc_chain[i])
			);
		end else begin : g_body
			scfr_cell u_cell (
				.clk      (clk),
				.shift_en (accept),
				.rx_byte  (rx_byte),
				.byte_in  (byte_chain[i-1]),
				.crc_in   (crc_chain[i-1]),
				.byte_q   (byte_chain[i]),
				.crc_q    (crc_chain[i])
			);
		end
	end

	assign match = (fill_q >= (scfr_pkg::WIN_LEN - 4'd1))
		&& (byte_chain[scfr_pkg::CELL_COUNT-1] == sync_q)
		&& (crc_chain[scfr_pkg::CELL_COUNT-1] == rx_byte);

	always_comb begin
		skip_next = skip_q;
		if (fill_q == scfr_pkg::WIN_LEN && skip_q != scfr_pkg::SKIP_MAX) begin
			skip_next = skip_q + 16'd1;
		end
	end

	always_comb begin
		new_frame.node_id       = byte_chain[6];
		new_frame.opcode        = byte_chain[5];
		new_frame.payload       = {byte_chain[1], byte_chain[2], byte_chain[3], byte_chain[4]};
		new_frame.seq           = byte_chain[0];
		new_frame.crc_byte      = rx_byte;
		new_frame.skipped_bytes = skip_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= scfr_pkg::SYNC_RESET;
			fill_q <= 4'd0;
			skip_q <= 16'd0;
		end else begin
			if (cfg_we) begin
				sync_q <= cfg_wdata;
			end
			if (accept) begin
				if (match) begin
					fill_q <= 4'd0;
					skip_q <= 16'd0;
				end else begin
					if (fill_q != scfr_pkg::WIN_LEN) begin
						fill_q <= fill_q + 4'd1;
					end
					skip_q <= skip_next;
				end
			end
		end
	end

	scfr_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept && match),
		.push_frame (new_frame),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_frame  (out_frame),
		.full       (buf_full)
	);

	assign node_id       = out_frame.node_id;
	assign opcode        = out_frame.opcode;
	assign payload       = out_frame.payload;
	assign seq           = out_frame.seq;
	assign crc_byte      = out_frame.crc_byte;
	assign skipped_bytes = out_frame.skipped_bytes;

endmodule

@@ rtl/scfr_checker.sv @@
// Port-level checker for the sync/CRC-8 frame receiver, bound to the top level.
// Depends only on the ports of sync_crc_frame_receiver_core.
module scfr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [7:0]         node_id,
	input logic [7:0]         opcode,
	input logic signed [31:0] payload,
	input logic [7:0]         seq,
	input logic [7:0]         crc_byte,
	input logic [15:0]        skipped_bytes
);

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no frame waiting");

	a_result_from_transaction: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("frame appeared without an input transaction");

	a_stall_from_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall rose without output backpressure");

	a_held_frame_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
			&& $stable({node_id, opcode, payload, seq, crc_byte, skipped_bytes}))
		else $error("stalled frame changed");

endmodule

bind sync_crc_frame_receiver_core scfr_checker u_scfr_checker (.*);

@@ verif/sync_crc_frame_receiver_core_test.sv @@
// Self-checking testbench for sync_crc_frame_receiver_core: random byte streams with
// embedded frames under random idling, checked against a frame-decoding scoreboard.
// Depends on scfr_pkg and the RTL of the frame receiver.
module sync_crc_frame_receiver_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	class frame_scoreboard;
		logic [7:0]       sync_byte;
		logic [7:0]       window [9];
		int unsigned      fill;
		logic [15:0]      skip_run;
		scfr_pkg::frame_t awaited [$];
		int unsigned      errors;
		int unsigned      frames_checked;

		function new();
			sync_byte = scfr_pkg::SYNC_RESET;
			foreach (window[i]) window[i] = 8'h00;
			fill = 0;
			skip_run = 16'h0000;
			errors = 0;
			frames_checked = 0;
		endfunction

		static function logic [7:0] head_crc(logic [63:0] head);
			logic [7:0] c;
			logic       fb;
			c = scfr_pkg::CRC_INIT;
			for (int i = 63; i >= 0; i--) begin
				fb = c[7] ^ head[i];
				c = {c[6:0], 1'b0} ^ (fb ? scfr_pkg::CRC_POLY : 8'h00);
			end
			return c;
		endfunction

		function void note_byte(logic [7:0] b);
			scfr_pkg::frame_t f;
			logic [63:0]      head;
			if (fill < 9) begin
				window[fill] = b;
				fill++;
			end else begin
				for (int i = 0; i < 8; i++) window[i] = window[i + 1];
				window[8] = b;
				if (skip_run != scfr_pkg::SKIP_MAX) skip_run++;
			end
			head = {window[0], window[1], window[2], window[3],
				window[4], window[5], window[6], window[7]};
			if (fill == 9 && window[0] == sync_byte && head_crc(head) == window[8]) begin
				f.node_id       = window[1];
				f.opcode        = window[2];
				f.payload       = {window[6], window[5], window[4], window[3]};
				f.seq           = window[7];
				f.crc_byte      = window[8];
				f.skipped_bytes = skip_run;
				awaited.push_back(f);
				foreach (window[i]) window[i] = 8'h00;
				fill = 0;
				skip_run = 16'h0000;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_frame(scfr_pkg::frame_t got);
			scfr_pkg::frame_t want;
			frames_checked++;
			if (awaited.size() == 0) begin
				$error("frame with node_id 0x%02h seq 0x%02h arrived with none expected",
					got.node_id, got.seq);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("node_id", 32'(want.node_id), 32'(got.node_id));
			compare_field("opcode", 32'(want.opcode), 32'(got.opcode));
			compare_field("payload", want.payload, got.payload);
			compare_field("seq", 32'(want.seq), 32'(got.seq));
			compare_field("crc_byte", 32'(want.crc_byte), 32'(got.crc_byte));
			compare_field("skipped_bytes", 32'(want.skipped_bytes), 32'(got.skipped_bytes));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [7:0]         cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         node_id;
	logic [7:0]         opcode;
	logic signed [31:0] payload;
	logic [7:0]         seq;
	logic [7:0]         crc_byte;
	logic [15:0]        skipped_bytes;

	frame_scoreboard  sb;
	scfr_pkg::frame_t got_frame;
	logic [7:0]       burst [$];
	bit               calm;
	int unsigned      sent_bytes;

	sync_crc_frame_receiver_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.node_id      (node_id),
		.opcode       (opcode),
		.payload      (payload),
		.seq          (seq),
		.crc_byte     (crc_byte),
		.skipped_bytes(skipped_bytes)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			got_frame.node_id       = node_id;
			got_frame.opcode        = opcode;
			got_frame.payload       = payload;
			got_frame.seq           = seq;
			got_frame.crc_byte      = crc_byte;
			got_frame.skipped_bytes = skipped_bytes;
			sb.check_frame(got_frame);
		end
	end

	initial begin
		int unsigned hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 8);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	task automatic send_byte(logic [7:0] b);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_byte(b);
		sent_bytes++;
	endtask

	task automatic send_burst();
		while (burst.size() != 0) send_byte(burst.pop_front());
	endtask

	function automatic void add_frame(logic [7:0] lead, logic [7:0] nid, logic [7:0] op,
		logic [31:0] value, logic [7:0] sq, bit damage);
		logic [63:0] head;
		int unsigned pos;
		head = {lead, nid, op, value[7:0], value[15:8], value[23:16], value[31:24], sq};
		for (int i = 7; i >= 0; i--) burst.push_back(head[i * 8 +: 8]);
		burst.push_back(frame_scoreboard::head_crc(head));
		if (damage) begin
			pos = burst.size() - 1 - $urandom_range(0, 8);
			burst[pos] = burst[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
	endfunction

	function automatic void add_noise(int unsigned count);
		repeat (count) burst.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_sync(logic [7:0] value);
		wait_for_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.sync_byte = value;
	endtask

	task automatic random_phase(logic [7:0] sync, int unsigned quota);
		int unsigned start;
		int unsigned pick;
		start = sent_bytes;
		set_sync(sync);
		while (sent_bytes - start < quota) begin
			calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 39);
			add_noise($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 4));
			if (pick < 28) begin
				add_frame(sync, 8'($urandom()), 8'($urandom()), $urandom(), 8'($urandom()), 1'b0);
			end else if (pick < 33) begin
				add_frame(sync, 8'($urandom()), 8'($urandom()), $urandom(), 8'($urandom()), 1'b1);
			end else if (pick < 37) begin
				add_frame(sync, 8'($urandom()), 8'($urandom()), $urandom(), 8'($urandom()), 1'b0);
				repeat ($urandom_range(1, 8)) void'(burst.pop_back());
			end else if (pick < 39) begin
				add_noise($urandom_range(1, 12));
			end else begin
				send_burst();
				wait_for_results();
			end
			send_burst();
		end
	endtask

	initial begin
		logic [7:0] sync_pick;
		sb = new();
		calm = 1'b0;
		sent_bytes = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 8'h00;
		in_valid  <= 1'b0;
		rx_byte   <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, skipped bytes ahead of a frame, a partial frame.
		add_frame(scfr_pkg::SYNC_RESET, 8'hFF, 8'h00, 32'h8000_0000, 8'hFF, 1'b0);
		burst.push_back(8'h00);
		burst.push_back(8'hFF);
		add_frame(scfr_pkg::SYNC_RESET, 8'h00, 8'hFF, 32'h7FFF_FFFF, 8'h00, 1'b0);
		burst.push_back(scfr_pkg::SYNC_RESET);
		burst.push_back(8'h01);
		burst.push_back(8'h80);
		burst.push_back(8'h7F);
		send_burst();

		// A short back-to-back run without the sync byte ahead of a frame.
		set_sync(8'h00);
		calm = 1'b1;
		repeat (20) send_byte(8'($urandom_range(1, 255)));
		add_frame(8'h00, 8'h5A, 8'hA5, 32'hFFFF_FFFF, 8'h3C, 1'b0);
		send_burst();
		calm = 1'b0;

		sync_pick = 8'($urandom_range(1, 254));
		random_phase(8'hFF, 270);
		random_phase(sync_pick, 270);
		random_phase(scfr_pkg::SYNC_RESET, 270);
		random_phase(8'($urandom()), 270);

		wait_for_results();
		repeat (6) @(posedge clk);
		$display("Sent %0d bytes and checked %0d frames under sync values 0xAA, 0x00, 0xFF,",
			sent_bytes, sb.frames_checked);
		$display("0x%02h and one more random one, with damaged and cut-short frames.",
			sync_pick);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#6ms;
		$error("run did not finish in time, %0d frames still expected", sb.awaited.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
